### sv/spt_pkg.sv
// spt_pkg: shared constants, sine table and controller/datapath structs
// for the sine pwm tone gate. no dependencies.
`default_nettype none

package spt_pkg;

  localparam int TABLE_LEN = 50;
  localparam int ROM_LEN   = 50;
  localparam int PHASE_W   = $clog2(TABLE_LEN);
  localparam int ROM_IDX_W = $clog2(ROM_LEN);

  localparam int VAL_W  = 15;
  localparam int FREQ_W = 16;
  localparam int BYTE_W = 8;
  localparam int SINE_W = 6;
  localparam int Q_W    = 10;
  localparam int DIV_W  = VAL_W + SINE_W;
  localparam int CNT_W  = $clog2(VAL_W + 1);

  localparam logic [VAL_W-1:0] PERIOD_RESET = VAL_W'(1000);
  localparam logic [VAL_W-1:0] DUTY_RESET   = VAL_W'(100);
  localparam logic [VAL_W-1:0] PERIOD_NUM   = VAL_W'(32400);

  // freq / 100 as (freq * 83887) >> 23, exact for all 16-bit freq
  localparam int FREQ_RECIP_W     = 17;
  localparam int FREQ_SHIFT       = 23;
  localparam int FREQ_PROD_W      = FREQ_W + FREQ_RECIP_W;
  localparam logic [FREQ_PROD_W-1:0] FREQ_RECIP = FREQ_PROD_W'(83887);

  // period * sine / 50 as (x * 1342178) >> 26, exact for x below 1864135
  localparam int AMP_RECIP_W = 21;
  localparam int AMP_SHIFT   = 26;
  localparam int AMP_PROD_W  = DIV_W + AMP_RECIP_W;
  localparam logic [AMP_PROD_W-1:0] AMP_RECIP = AMP_PROD_W'(1342178);

  // divider steps, one per dividend bit
  localparam logic [CNT_W-1:0] PERIOD_STEPS = CNT_W'(VAL_W);

  localparam logic [1:0] CMD_TONE  = 2'd0;
  localparam logic [1:0] CMD_PHASE = 2'd1;
  localparam logic [1:0] CMD_GATE  = 2'd2;

  localparam logic [SINE_W-1:0] SINE_ROM [ROM_LEN] = '{
    6'd25, 6'd28, 6'd31, 6'd34, 6'd37, 6'd40, 6'd42, 6'd44, 6'd46, 6'd48,
    6'd49, 6'd50, 6'd50, 6'd50, 6'd50, 6'd49, 6'd48, 6'd46, 6'd44, 6'd42,
    6'd40, 6'd37, 6'd34, 6'd31, 6'd28, 6'd25, 6'd22, 6'd19, 6'd16, 6'd13,
    6'd10, 6'd8,  6'd6,  6'd4,  6'd2,  6'd1,  6'd0,  6'd0,  6'd0,  6'd0,
    6'd1,  6'd2,  6'd4,  6'd6,  6'd8,  6'd10, 6'd13, 6'd16, 6'd19, 6'd22
  };

  typedef struct packed {
    logic take;
    logic prep;
    logic start;
    logic step;
    logic commit;
    logic emit;
  } spt_ctl_t;

  typedef struct packed {
    logic [1:0] op;
    logic       q_zero;
    logic       div_last;
    logic       div_nz;
    logic       out_free;
  } spt_sts_t;

endpackage

`default_nettype wire

### sv/spt_ctrl.sv
// spt_ctrl: sequencing state machine for the sine pwm tone gate.
// depends on spt_pkg; drives spt_dp through spt_ctl_t.
`default_nettype none

module spt_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire spt_pkg::spt_sts_t sts_i,
  output spt_pkg::spt_ctl_t      ctl_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PREP   = 3'd1;
  localparam logic [2:0] ST_START  = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_COMMIT = 3'd4;
  localparam logic [2:0] ST_FIN    = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_PREP;
      end
      ST_PREP: begin
        priority if (sts_i.op == spt_pkg::CMD_TONE) begin
          state_d = ST_START;
        end else if (sts_i.op == spt_pkg::CMD_PHASE) begin
          state_d = ST_COMMIT;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_START: begin
        priority if (sts_i.op == spt_pkg::CMD_TONE && sts_i.q_zero) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts_i.div_last) state_d = ST_COMMIT;
      end
      ST_COMMIT: state_d = ST_FIN;
      ST_FIN: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign ctl_o.take    = (state_q == ST_IDLE) && in_valid_i;
  assign ctl_o.prep    = (state_q == ST_PREP);
  assign ctl_o.start   = (state_q == ST_START);
  assign ctl_o.step    = (state_q == ST_DIV);
  assign ctl_o.commit  = (state_q == ST_COMMIT);
  assign ctl_o.emit    = (state_q == ST_FIN) && sts_i.out_free;

  // divider never runs with a zero divisor
  a_div_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> sts_i.div_nz)
    else $error("divider stepping with zero divisor");

  // finished word waits while the output slot is taken
  a_fin_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && !sts_i.out_free) |=> (state_q == ST_FIN))
    else $error("result dropped while output slot busy");

endmodule

`default_nettype wire

### sv/spt_dp.sv
// spt_dp: datapath of the sine pwm tone gate: tone state, reciprocal
// multiplies, radix-2 divider and output register. depends on spt_pkg.
`default_nettype none

module spt_dp (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire spt_pkg::spt_ctl_t         ctl_i,
  output spt_pkg::spt_sts_t              sts_o,
  input  wire logic [1:0]                cmd_i,
  input  wire logic [spt_pkg::BYTE_W-1:0] freq_lo_i,
  input  wire logic [spt_pkg::BYTE_W-1:0] freq_hi_i,
  input  wire logic [spt_pkg::BYTE_W-1:0] duration_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic [spt_pkg::VAL_W-1:0]      period_value_o,
  output logic [spt_pkg::VAL_W-1:0]      duty_value_o,
  output logic                           tone_on_o,
  output logic                           div_error_o
);

  // latched word
  logic [1:0]                       op_q;
  logic [spt_pkg::FREQ_W-1:0]       freq_q;
  logic [spt_pkg::BYTE_W-1:0]       dur_q;

  // tone state
  logic [spt_pkg::VAL_W-1:0]        period_q, duty_q, gate_q;
  logic [spt_pkg::PHASE_W-1:0]      phase_q;
  logic [spt_pkg::ROM_IDX_W-1:0]    idx_q;
  logic [spt_pkg::BYTE_W-1:0]       limit_q;
  logic                             tone_q, err_q;

  // arithmetic
  logic [spt_pkg::Q_W-1:0]          q_q;
  logic [spt_pkg::DIV_W-1:0]        prod_q;
  logic [spt_pkg::FREQ_PROD_W-1:0]  freq_prod;
  logic [spt_pkg::DIV_W-1:0]        duty_prod;
  logic [spt_pkg::AMP_PROD_W-1:0]   amp_prod;
  logic [spt_pkg::VAL_W-1:0]        limit_x80;

  // divider
  logic [spt_pkg::Q_W-1:0]          rem_q, dvs_q;
  logic [spt_pkg::VAL_W-1:0]        quo_q;
  logic [spt_pkg::CNT_W-1:0]        cnt_q;
  logic [spt_pkg::Q_W:0]            rem_sh;
  logic [spt_pkg::Q_W+1:0]          rem_diff;

  // output register
  logic                             out_valid_q;
  logic [spt_pkg::VAL_W-1:0]        out_period_q, out_duty_q;
  logic                             out_tone_q, out_err_q;

  assign freq_prod = spt_pkg::FREQ_PROD_W'(freq_q) * spt_pkg::FREQ_RECIP;
  assign duty_prod = spt_pkg::DIV_W'(period_q) * spt_pkg::DIV_W'(spt_pkg::SINE_ROM[idx_q]);
  assign amp_prod  = spt_pkg::AMP_PROD_W'(prod_q) * spt_pkg::AMP_RECIP;
  assign limit_x80 = spt_pkg::VAL_W'({limit_q, 6'b0}) + spt_pkg::VAL_W'({limit_q, 4'b0});

  assign rem_sh   = {rem_q, quo_q[spt_pkg::VAL_W-1]};
  assign rem_diff = {1'b0, rem_sh} - {2'b0, dvs_q};

  assign sts_o.op       = op_q;
  assign sts_o.q_zero   = (q_q == '0);
  assign sts_o.div_last = (cnt_q == spt_pkg::CNT_W'(1));
  assign sts_o.div_nz   = (dvs_q != '0);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  // word latch and reciprocal/product registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.take) begin
      op_q   <= cmd_i;
      freq_q <= {freq_hi_i, freq_lo_i};
      dur_q  <= duration_i;
    end
    if (ctl_i.prep) begin
      q_q    <= freq_prod[spt_pkg::FREQ_PROD_W-1 -: spt_pkg::Q_W];
      prod_q <= duty_prod;
    end
  end

  // radix-2 restoring divider for the period, one quotient bit a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rem_q <= '0;
      quo_q <= '0;
      dvs_q <= '0;
    end else if (ctl_i.start) begin
      rem_q <= '0;
      quo_q <= spt_pkg::PERIOD_NUM;
      dvs_q <= q_q;
      cnt_q <= spt_pkg::PERIOD_STEPS;
    end else if (ctl_i.step) begin
      cnt_q <= cnt_q - spt_pkg::CNT_W'(1);
      if (!rem_diff[spt_pkg::Q_W+1]) begin
        rem_q <= rem_diff[spt_pkg::Q_W-1:0];
        quo_q <= {quo_q[spt_pkg::VAL_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[spt_pkg::Q_W-1:0];
        quo_q <= {quo_q[spt_pkg::VAL_W-2:0], 1'b0};
      end
    end
  end

  // tone state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= spt_pkg::PERIOD_RESET;
      duty_q   <= spt_pkg::DUTY_RESET;
      phase_q  <= '0;
      idx_q    <= '0;
      gate_q   <= '0;
      limit_q  <= '0;
      tone_q   <= 1'b0;
      err_q    <= 1'b0;
    end else begin
      if (ctl_i.take) begin
        err_q <= 1'b0;
      end
      if (ctl_i.prep && op_q == spt_pkg::CMD_GATE) begin
        if (gate_q < limit_x80) begin
          gate_q <= gate_q + spt_pkg::VAL_W'(1);
          tone_q <= 1'b1;
        end else begin
          tone_q <= 1'b0;
        end
      end
      if (ctl_i.start && op_q == spt_pkg::CMD_TONE) begin
        limit_q <= dur_q;
        gate_q  <= '0;
        if (q_q == '0) err_q <= 1'b1;
      end
      if (ctl_i.commit) begin
        if (op_q == spt_pkg::CMD_TONE) begin
          period_q <= quo_q;
        end else begin
          duty_q <= amp_prod[spt_pkg::AMP_SHIFT +: spt_pkg::VAL_W];
          if (phase_q == spt_pkg::PHASE_W'(spt_pkg::TABLE_LEN - 1)) begin
            phase_q <= '0;
            idx_q   <= '0;
          end else begin
            phase_q <= phase_q + spt_pkg::PHASE_W'(1);
            if (idx_q == spt_pkg::ROM_IDX_W'(spt_pkg::ROM_LEN - 1)) begin
              idx_q <= '0;
            end else begin
              idx_q <= idx_q + spt_pkg::ROM_IDX_W'(1);
            end
          end
        end
      end
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.emit) begin
      out_period_q <= period_q;
      out_duty_q   <= duty_q;
      out_tone_q   <= tone_q;
      out_err_q    <= err_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign period_value_o = out_period_q;
  assign duty_value_o   = out_duty_q;
  assign tone_on_o      = out_tone_q;
  assign div_error_o    = out_err_q;

  // duty is a fraction of the period it was scaled from
  a_duty_le_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.commit && op_q == spt_pkg::CMD_PHASE) |=> (duty_q <= period_q))
    else $error("duty above period after phase tick");

  // gate counter never passes its limit
  a_gate_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gate_q <= limit_x80)
    else $error("gate count beyond duration limit");

endmodule

`default_nettype wire

### sv/sine_pwm_tone_gate.sv
// Sine pwm tone generator with timed output gate. Words are handled one at a time, and the
// result word shows in the same cycle that the next word can be taken. A tone command runs
// the one-bit-per-cycle divider in spt_dp, which needs 15 steps for 32400 / (freq / 100). A
// tone command with freq below 100 skips the divider. A phase tick needs no divider, as
// period * sine / 50 is a reciprocal multiply. A gate tick or an unused code goes from the prep
// state straight to the finish state. A finished word sits in the output register, so input
// is taken again while it waits; a new result is held back only while that register is still
// stalled.
// depends on spt_pkg, spt_ctrl and spt_dp.
`default_nettype none

module sine_pwm_tone_gate (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [1:0]                 cmd_i,
  input  wire logic [spt_pkg::BYTE_W-1:0] freq_lo_i,
  input  wire logic [spt_pkg::BYTE_W-1:0] freq_hi_i,
  input  wire logic [spt_pkg::BYTE_W-1:0] duration_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [spt_pkg::VAL_W-1:0]       period_value_o,
  output logic [spt_pkg::VAL_W-1:0]       duty_value_o,
  output logic                            tone_on_o,
  output logic                            div_error_o
);

  spt_pkg::spt_ctl_t ctl;
  spt_pkg::spt_sts_t sts;

  spt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  spt_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .sts_o          (sts),
    .cmd_i          (cmd_i),
    .freq_lo_i      (freq_lo_i),
    .freq_hi_i      (freq_hi_i),
    .duration_i     (duration_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .period_value_o (period_value_o),
    .duty_value_o   (duty_value_o),
    .tone_on_o      (tone_on_o),
    .div_error_o    (div_error_o)
  );

endmodule

`default_nettype wire
